// ===== design/wfd_pkg.sv =====
`default_nettype none
package wfd_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_PAYLOAD = 3'd3
  } phase_t;

  // frame classes
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_PING  = 2'd2
  } kind_t;

  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // one result item
  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      frame_kind;
    logic [3:0] frame_opcode;
    logic       last_in_frame;
    logic       empty_frame;
  } result_t;

  function automatic kind_t kind_of(input logic [3:0] op);
    case (op)
      OP_CLOSE: kind_of = KIND_CLOSE;
      OP_PING:  kind_of = KIND_PING;
      default:  kind_of = KIND_DATA;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/wfd_in_reg.sv =====
`default_nettype none
module wfd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            stage_valid,
  output logic [7:0]      stage_byte
);
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end
endmodule
`default_nettype wire

// ===== design/wfd_parser.sv =====
`default_nettype none
module wfd_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output wfd_pkg::result_t      res
);
  import wfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [6:0]  len7;
  logic [63:0] shifted;
  logic [63:0] dec;
  logic [3:0]  ext_dec;

  assign len7    = rx_byte[6:0];
  assign shifted = {remain_r[55:0], rx_byte};
  assign dec     = (remain_r != 64'd0) ? remain_r - 64'd1 : remain_r;
  assign ext_dec = (ext_left_r != 4'd0) ? ext_left_r - 4'd1 : ext_left_r;

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    remain_nxt   = remain_r;
    ext_left_nxt = ext_left_r;
    case (phase_r)
      PH_LEN: begin
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          ext_left_nxt = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          remain_nxt   = 64'd0;
          phase_nxt    = PH_EXT;
        end else begin
          remain_nxt = {57'd0, len7};
          phase_nxt  = (len7 == 7'd0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_EXT: begin
        remain_nxt   = shifted;
        ext_left_nxt = ext_dec;
        if (ext_dec == 4'd0) begin
          phase_nxt = (shifted == 64'd0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remain_nxt = dec;
        if (dec == 64'd0) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        opcode_nxt   = rx_byte[3:0];
        remain_nxt   = 64'd0;
        ext_left_nxt = 4'd0;
        phase_nxt    = PH_LEN;
      end
    endcase
  end

  // outputs
  always_comb begin
    res_valid         = 1'b0;
    res.data_byte     = 8'd0;
    res.frame_kind    = kind_of(opcode_r);
    res.frame_opcode  = opcode_r;
    res.last_in_frame = 1'b1;
    res.empty_frame   = 1'b1;
    case (phase_r)
      PH_LEN: begin
        res_valid = step && (len7 == 7'd0);
      end
      PH_EXT: begin
        res_valid = step && (ext_dec == 4'd0) && (shifted == 64'd0);
      end
      PH_PAYLOAD: begin
        res_valid         = step;
        res.data_byte     = rx_byte;
        res.last_in_frame = (dec == 64'd0);
        res.empty_frame   = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      opcode_r   <= 4'd0;
      remain_r   <= 64'd0;
      ext_left_r <= 4'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      remain_r   <= remain_nxt;
      ext_left_r <= ext_left_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/wfd_out_reg.sv =====
`default_nettype none
module wfd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load_en,
  input  wire logic             res_valid,
  input  wire wfd_pkg::result_t res,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wfd_pkg::result_t      out_res
);
  import wfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = load_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_en && res_valid) begin
      res_r <= res;
    end
  end
endmodule
`default_nettype wire

// ===== design/websocket_frame_decoder.sv =====
`default_nettype none
// channel   ports                                   direction
// -------   -------------------------------------   ---------
// in        in_valid, in_ready, in_rx_byte          byte stream in
// out       out_valid, out_ready, out_data_byte,    result out
//           out_frame_kind, out_frame_opcode,
//           out_last_in_frame, out_empty_frame
//
// one byte per clock unless out stalls; out_valid comes from the result register
// the header parser and 64-bit length counter take a byte on every step
// header bytes give a result only to end an empty frame, so the out side sees gaps
// rst_n is synchronous, active low, and returns the parser to the first header byte
// a stall on out holds the result register and the input register fills behind it
module websocket_frame_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_frame_kind,
  output logic [3:0]      out_frame_opcode,
  output logic            out_last_in_frame,
  output logic            out_empty_frame
);
  import wfd_pkg::*;

  logic       advance;     // result register can take a new value
  logic       stage_valid; // a byte waits in the input register
  logic [7:0] stage_byte;
  logic       step;        // byte moves through the parser this cycle
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // a byte is consumed only when the result register is free to catch its result
  assign step = stage_valid && advance;

  wfd_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_rx_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  // header state machine and payload counter
  wfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (stage_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register, parts the parser from the out transfer
  wfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (stage_valid),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_data_byte     = out_res.data_byte;
  assign out_frame_kind    = out_res.frame_kind;
  assign out_frame_opcode  = out_res.frame_opcode;
  assign out_last_in_frame = out_res.last_in_frame;
  assign out_empty_frame   = out_res.empty_frame;
endmodule
`default_nettype wire
